>>> hdl/bld_pkg.sv
`timescale 1ns / 1ps
package bld_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam logic [7:0] ALL_BUTTONS = 8'((1 << NUM_BUTTONS) - 1);

  localparam logic [15:0] RESET_PERIOD = 16'd12500;

  // register indexes
  localparam logic [1:0] REG_ENABLE_MASK    = 2'd0;
  localparam logic [1:0] REG_LOCKOUT_MASK   = 2'd1;
  localparam logic [1:0] REG_LOCKOUT_PERIOD = 2'd2;

  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] pins;
    logic       tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0] button_index;
    logic       pressed;
    logic       last;
  } out_item_t;

  // all events caused by one item
  typedef struct packed {
    logic [7:0] events;
    logic [7:0] pressed;
  } ev_word_t;

endpackage

>>> hdl/button_lockout_debouncer.sv
`timescale 1ns / 1ps
// Eight-button debouncer with a shared lockout timer. Each item is one pin sample plus a
// timer tick; an item is taken every clock while in_full is low, and its state update
// (timer, lockout flags, stable levels) completes in that cycle. Items that cause events
// leave one word in a four-entry event queue; the output side sends one event per clock
// while out_pop is high, lowest button first, so an item with several events holds the
// output until its last event is taken. in_full rises only when the queue fills.
// Configuration writes take effect on the next clock.
module button_lockout_debouncer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  bld_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output bld_pkg::out_item_t out_item
);
  import bld_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_not_empty;
  ev_word_t q_wdata;
  ev_word_t q_rdata;

  assign in_full = q_full;

  bld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_wdata)
  );

  bld_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  bld_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_word      (q_rdata),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item)
  );

`ifndef SYNTHESIS
  // events of one item come out in rising button order
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_item.last) |=>
      (!out_empty && out_item.button_index > $past(out_item.button_index)))
    else $error("events of one item out of order");

  // a full queue means the output side already holds a word
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("queue full while output idle");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (32'(out_item.button_index) < NUM_BUTTONS))
    else $error("button index out of range");
`endif

endmodule

>>> hdl/bld_front.sv
`timescale 1ns / 1ps
module bld_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_push,
  input  bld_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output bld_pkg::ev_word_t q_word
);
  import bld_pkg::*;

  logic [7:0]  enable_mask_r;
  logic [7:0]  lockout_mask_r;
  logic [15:0] period_r;
  logic [7:0]  stable_r, stable_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic        running_r, running_nxt;
  logic [15:0] count_r, count_nxt;

  logic        accept;
  logic        run;
  logic        expire;
  logic [16:0] count_inc;
  logic [7:0]  flags_t;
  logic        running_t;
  logic [7:0]  level;
  logic [7:0]  changed;
  logic [7:0]  ignored;
  logic [7:0]  events;
  logic [7:0]  new_locks;

  assign accept = in_push && !q_full;

  always_comb begin
    run       = in_item.tick && running_r;
    count_inc = {1'b0, count_r} + 17'd1;
    expire    = run && (count_inc >= {1'b0, period_r});
    flags_t   = expire ? '0 : flags_r;
    running_t = expire ? 1'b0 : running_r;
    if (expire) begin
      count_nxt = '0;
    end else if (run) begin
      count_nxt = count_inc[15:0];
    end else begin
      count_nxt = count_r;
    end

    level     = in_item.pins & enable_mask_r & ALL_BUTTONS;
    changed   = (stable_r ^ level) & ALL_BUTTONS;
    // locked buttons keep their stable level
    ignored   = changed & lockout_mask_r & flags_t;
    events    = changed & ~ignored;
    new_locks = events & lockout_mask_r;

    flags_nxt   = flags_t | new_locks;
    running_nxt = running_t || (|new_locks);
    stable_nxt  = (level ^ ignored) & ALL_BUTTONS;
  end

  assign q_push         = accept && (|events);
  assign q_word.events  = events;
  assign q_word.pressed = ~level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r  <= 8'hFF;
      lockout_mask_r <= 8'hFF;
      period_r       <= RESET_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_MASK:    enable_mask_r  <= cfg_wdata[7:0];
        REG_LOCKOUT_MASK:   lockout_mask_r <= cfg_wdata[7:0];
        REG_LOCKOUT_PERIOD: period_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r  <= ALL_BUTTONS;
      flags_r   <= '0;
      running_r <= 1'b0;
      count_r   <= '0;
    end else if (accept) begin
      stable_r  <= stable_nxt;
      flags_r   <= flags_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

>>> hdl/bld_fifo.sv
`timescale 1ns / 1ps
module bld_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bld_pkg::ev_word_t wdata,
  input  logic              pop,
  output bld_pkg::ev_word_t rdata,
  output logic              full,
  output logic              not_empty
);
  import bld_pkg::*;

  ev_word_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/bld_back.sv
`timescale 1ns / 1ps
module bld_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  bld_pkg::ev_word_t  q_word,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output bld_pkg::out_item_t out_item
);
  import bld_pkg::*;

  logic [7:0] mask_r, mask_nxt;
  logic [7:0] press_r;
  logic [2:0] idx;
  logic [7:0] rest;
  logic       take;
  logic       load;

  // lowest pending event goes first
  always_comb begin
    idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = 3'(i);
      end
    end
  end

  assign out_empty = (mask_r == '0);
  assign rest      = mask_r & (mask_r - 8'd1);
  assign take      = out_pop && !out_empty;
  assign load      = q_not_empty && (out_empty || (take && rest == '0));
  assign q_pop     = load;

  assign out_item.button_index = idx;
  assign out_item.pressed      = press_r[idx];
  assign out_item.last         = (rest == '0);

  always_comb begin
    if (load) begin
      mask_nxt = q_word.events;
    end else if (take) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press_r <= q_word.pressed;
    end
  end

endmodule
